>>> rtl/core/multi_camera_reprojection_inlier_counter_core_macros.svh
// Assertion macros shared by the checker of the inlier scoring core.
`ifndef MULTI_CAMERA_REPROJECTION_INLIER_COUNTER_CORE_MACROS_SVH
`define MULTI_CAMERA_REPROJECTION_INLIER_COUNTER_CORE_MACROS_SVH

// Property sampled on clk, switched off while rst is high.
`define MCRIC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property sampled on clk, also checked during reset.
`define MCRIC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/mcric_pkg.sv
// Types, constants and helper functions of the inlier scoring core.
`default_nettype none
package mcric_pkg;

  localparam int NUM_CAMERAS_DEF = 4;
  localparam int MAX_OBSERVATIONS_DEF = 65536;
  localparam int MOUNT_WORDS = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int QW = $clog2(QUEUE_DEPTH);

  // 0.05 m in 1/1024 m units, rounded up
  localparam logic signed [26:0] DEPTH_MIN = 27'sd52;
  localparam logic signed [43:0] POS_MAX = 44'sd67108863;
  localparam logic signed [43:0] POS_MIN = -44'sd67108864;

  // request kinds
  localparam logic ACT_SCORE = 1'b0;
  localparam logic ACT_MOUNT = 1'b1;

  // configuration register indexes
  localparam logic [2:0] CFG_ROT_ROW_A    = 3'd0;
  localparam logic [2:0] CFG_ROT_ROW_B    = 3'd1;
  localparam logic [2:0] CFG_ROT_ROW_C    = 3'd2;
  localparam logic [2:0] CFG_TRANS_XY     = 3'd3;
  localparam logic [2:0] CFG_TRANS_Z      = 3'd4;
  localparam logic [2:0] CFG_FOCAL        = 3'd5;
  localparam logic [2:0] CFG_PRINCIPAL    = 3'd6;
  localparam logic [2:0] CFG_MAX_ERROR    = 3'd7;

  typedef struct packed {
    logic               action;
    logic [1:0]         camera;
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic signed [23:0] point_z;
    logic [15:0]        meas_u;
    logic [15:0]        meas_v;
    logic [1:0]         word_index;
    logic [63:0]        word_value;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic [15:0] obs_index;
    logic        in_front;
    logic        inlier;
    logic [15:0] inlier_count;
    logic        pass_done;
  } out_item_t;

  typedef struct packed {
    logic [2:0][47:0] rot;
    logic [47:0]      trans_xy;
    logic [23:0]      trans_z;
    logic [15:0]      focal;
    logic [31:0]      principal;
    logic [11:0]      max_err;
  } cfg_t;

  // request as it travels from front to back
  typedef struct packed {
    logic               is_mount;
    logic               cam_ok;
    logic [1:0]         camera;
    logic signed [24:0] d0;
    logic signed [24:0] d1;
    logic signed [24:0] d2;
    logic [15:0]        meas_u;
    logic [15:0]        meas_v;
    logic [1:0]         word_index;
    logic [63:0]        word_value;
    logic               last;
  } q_entry_t;

  // Q1.14 entry k of a packed rotation row
  function automatic logic signed [15:0] row_entry(input logic [47:0] row,
                                                   input logic [1:0] k);
    logic signed [15:0] r;
    case (k)
      2'd0: r = row[15:0];
      2'd1: r = row[31:16];
      default: r = row[47:32];
    endcase
    return r;
  endfunction

  // round to 1/1024 m (add half, floor shift by 14), saturate to 27 bits
  function automatic logic signed [26:0] round_sat(input logic signed [57:0] v);
    logic signed [57:0] t;
    logic signed [43:0] s;
    logic signed [26:0] r;
    t = v + 58'sd8192;
    s = 44'(t >>> 14);
    if (s > POS_MAX) r = 27'(POS_MAX);
    else if (s < POS_MIN) r = 27'(POS_MIN);
    else r = 27'(s);
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/mcric_front.sv
// Front end: takes requests, classifies them and forms the map offsets.
`default_nettype none
module mcric_front #(
  parameter int NUM_CAMERAS = mcric_pkg::NUM_CAMERAS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire mcric_pkg::cfg_t     cfg,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire mcric_pkg::in_item_t in_item,
  output logic                     q_push,
  input  wire logic                q_ready,
  output mcric_pkg::q_entry_t      q_data
);
  import mcric_pkg::*;

  logic               f_valid;
  q_entry_t           f_entry;
  q_entry_t           entry_in;
  logic               f_drop;
  logic               f_done;
  logic signed [23:0] tx, ty, tz;

  assign tx = cfg.trans_xy[23:0];
  assign ty = cfg.trans_xy[47:24];
  assign tz = cfg.trans_z;

  // classify and subtract body position
  always_comb begin
    entry_in = '0;
    entry_in.is_mount   = (in_item.action == ACT_MOUNT);
    entry_in.cam_ok     = (32'(in_item.camera) < NUM_CAMERAS);
    entry_in.camera     = in_item.camera;
    entry_in.d0         = 25'(in_item.point_x) - 25'(tx);
    entry_in.d1         = 25'(in_item.point_y) - 25'(ty);
    entry_in.d2         = 25'(in_item.point_z) - 25'(tz);
    entry_in.meas_u     = in_item.meas_u;
    entry_in.meas_v     = in_item.meas_v;
    entry_in.word_index = in_item.word_index;
    entry_in.word_value = in_item.word_value;
    entry_in.last       = in_item.last;
  end

  // mount writes for a missing camera are dropped here
  assign f_drop   = f_entry.is_mount && !f_entry.cam_ok;
  assign q_push   = f_valid && !f_drop;
  assign q_data   = f_entry;
  assign f_done   = f_valid && (f_drop || q_ready);
  assign in_stall = f_valid && !f_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      f_valid <= 1'b1;
    end else if (f_done) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      f_entry <= entry_in;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/mcric_queue.sv
// Short request queue between front and back.
`default_nettype none
module mcric_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  output logic                     push_ready,
  input  wire mcric_pkg::q_entry_t push_data,
  output logic                     pop_valid,
  input  wire logic                pop,
  output mcric_pkg::q_entry_t      pop_data
);
  import mcric_pkg::*;

  q_entry_t      slots [QUEUE_DEPTH];
  logic [QW-1:0] wr_ptr;
  logic [QW-1:0] rd_ptr;
  logic [QW:0]   count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != (QW + 1)'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

endmodule
`default_nettype wire

>>> rtl/core/mcric_back.sv
// Back end: mount table, shared multiplier sequencer, counters and result register.
`default_nettype none
module mcric_back #(
  parameter int NUM_CAMERAS      = mcric_pkg::NUM_CAMERAS_DEF,
  parameter int MAX_OBSERVATIONS = mcric_pkg::MAX_OBSERVATIONS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire mcric_pkg::cfg_t     cfg,
  input  wire logic                q_valid,
  output logic                     q_pop,
  input  wire mcric_pkg::q_entry_t q_entry,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output mcric_pkg::out_item_t     out_item
);
  import mcric_pkg::*;

  localparam int DEPTH = NUM_CAMERAS * MOUNT_WORDS;
  localparam int AW    = $clog2(DEPTH);
  localparam int OW    = $clog2(MAX_OBSERVATIONS);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_ROT1, S_DIFF, S_ROT2, S_ERR, S_MAG, S_SQ, S_EMIT
  } state_t;

  state_t             state;
  q_entry_t           item;
  logic [2:0]         cnt;
  logic [1:0]         ri;
  logic [2:0]         cj;
  logic               phase;

  logic [63:0]        mtab [DEPTH];
  logic [63:0]        mem_rd;
  logic               mem_we;
  logic [AW-1:0]      waddr;
  logic [AW-1:0]      raddr;

  logic [2:0][47:0]   mrow;
  logic [63:0]        moff;
  logic signed [26:0] xb [3];
  logic signed [27:0] e  [3];
  logic signed [26:0] xc [3];
  logic signed [57:0] prod;
  logic signed [57:0] acc;
  logic signed [57:0] sum;
  logic signed [43:0] ex, ey;
  logic [43:0]        tz;
  logic [43:0]        mex, mey, mtz;
  logic [87:0]        sacc, lacc;
  logic [87:0]        term;
  logic               front;

  logic signed [28:0] op_a, op_b;
  logic signed [16:0] dx, dy;
  logic [43:0]        sq_v;
  logic signed [20:0] off0, off1, off2;

  logic [15:0]        running;
  logic [OW-1:0]      obs_cnt;
  logic [15:0]        run_next;
  logic               inl;
  logic               can_emit;

  // mount table: written on pop, read one word a cycle while loading
  assign mem_we = (state == S_IDLE) && q_valid && q_entry.is_mount;
  assign waddr  = AW'({q_entry.camera, q_entry.word_index});
  assign raddr  = AW'({item.camera, cnt[1:0]});

  always_ff @(posedge clk) begin
    if (mem_we) mtab[waddr] <= q_entry.word_value;
    mem_rd <= mtab[raddr];
  end

  assign q_pop = (state == S_IDLE) && q_valid;

  // operand selection for the shared multiplier
  assign dx   = $signed({1'b0, cfg.principal[15:0]}) - $signed({1'b0, item.meas_u});
  assign dy   = $signed({1'b0, cfg.principal[31:16]}) - $signed({1'b0, item.meas_v});
  assign off0 = moff[20:0];
  assign off1 = moff[41:21];
  assign off2 = moff[62:42];

  always_comb begin
    case (ri)
      2'd0:    sq_v = mex;
      2'd1:    sq_v = mey;
      default: sq_v = mtz;
    endcase
  end

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state)
      S_ROT1: begin
        op_a = 29'(row_entry(cfg.rot[ri], cj[1:0]));
        case (cj[1:0])
          2'd0:    op_b = 29'(item.d0);
          2'd1:    op_b = 29'(item.d1);
          default: op_b = 29'(item.d2);
        endcase
      end
      S_ROT2: begin
        op_a = 29'(row_entry(mrow[ri], cj[1:0]));
        op_b = 29'(e[cj[1:0]]);
      end
      S_ERR: begin
        case (cj)
          3'd0: begin
            op_a = 29'($signed({1'b0, cfg.focal}));
            op_b = 29'(xc[0]);
          end
          3'd1: begin
            op_a = 29'(dx);
            op_b = 29'(xc[2]);
          end
          3'd2: begin
            op_a = 29'($signed({1'b0, cfg.focal}));
            op_b = 29'(xc[1]);
          end
          3'd3: begin
            op_a = 29'(dy);
            op_b = 29'(xc[2]);
          end
          default: begin
            op_a = 29'($signed({1'b0, cfg.max_err}));
            op_b = 29'(xc[2]);
          end
        endcase
      end
      S_SQ: begin
        case (cj)
          3'd0: begin
            op_a = 29'($signed({1'b0, sq_v[43:22]}));
            op_b = 29'($signed({1'b0, sq_v[43:22]}));
          end
          3'd1: begin
            op_a = 29'($signed({1'b0, sq_v[43:22]}));
            op_b = 29'($signed({1'b0, sq_v[21:0]}));
          end
          default: begin
            op_a = 29'($signed({1'b0, sq_v[21:0]}));
            op_b = 29'($signed({1'b0, sq_v[21:0]}));
          end
        endcase
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign sum = acc + prod;

  // square partial product placed at its weight
  always_comb begin
    case (cj)
      3'd0:    term = 88'(prod[43:0]) << 44;
      3'd1:    term = 88'(prod[43:0]) << 23;
      default: term = 88'(prod[43:0]);
    endcase
  end

  assign inl      = front && (sacc < lacc);
  assign run_next = (inl && running != 16'hFFFF) ? running + 16'd1 : running;
  assign can_emit = !out_valid || !out_stall;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      ri        <= '0;
      cj        <= '0;
      phase     <= 1'b0;
      running   <= '0;
      obs_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      // result taken; a new one from S_EMIT overrides below
      if (out_valid && !out_stall && state != S_EMIT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            item <= q_entry;
            if (!q_entry.is_mount) begin
              state <= S_LOAD;
              cnt   <= '0;
            end
          end
        end
        S_LOAD: begin
          cnt <= cnt + 3'd1;
          if (cnt != 3'd0) begin
            if (cnt == 3'd4) begin
              moff  <= item.cam_ok ? mem_rd : '0;
              state <= S_ROT1;
              ri    <= '0;
              cj    <= '0;
              phase <= 1'b0;
              acc   <= '0;
            end else begin
              mrow[cnt[1:0] - 2'd1] <= item.cam_ok ? mem_rd[47:0] : '0;
            end
          end
        end
        S_ROT1, S_ROT2: begin
          if (!phase) begin
            prod  <= op_a * op_b;
            phase <= 1'b1;
          end else begin
            phase <= 1'b0;
            if (cj == 3'd2) begin
              if (state == S_ROT1) xb[ri] <= round_sat(sum);
              else xc[ri] <= round_sat(sum);
              acc <= '0;
              cj  <= '0;
              if (ri == 2'd2) begin
                ri    <= '0;
                state <= (state == S_ROT1) ? S_DIFF : S_ERR;
              end else begin
                ri <= ri + 2'd1;
              end
            end else begin
              acc <= sum;
              cj  <= cj + 3'd1;
            end
          end
        end
        S_DIFF: begin
          e[0]  <= 28'(xb[0]) - 28'(off0);
          e[1]  <= 28'(xb[1]) - 28'(off1);
          e[2]  <= 28'(xb[2]) - 28'(off2);
          state <= S_ROT2;
        end
        S_ERR: begin
          if (!phase) begin
            prod  <= op_a * op_b;
            phase <= 1'b1;
          end else begin
            phase <= 1'b0;
            cj    <= cj + 3'd1;
            case (cj)
              3'd1: begin
                ex  <= sum[43:0];
                acc <= '0;
              end
              3'd3: begin
                ey  <= sum[43:0];
                acc <= '0;
              end
              3'd4: begin
                tz    <= sum[43:0];
                state <= S_MAG;
              end
              default: acc <= sum;
            endcase
          end
        end
        S_MAG: begin
          mex   <= ex[43] ? 44'(-ex) : 44'(ex);
          mey   <= ey[43] ? 44'(-ey) : 44'(ey);
          mtz   <= tz;
          front <= (xc[2] >= DEPTH_MIN);
          sacc  <= '0;
          lacc  <= '0;
          ri    <= '0;
          cj    <= '0;
          state <= S_SQ;
        end
        S_SQ: begin
          if (!phase) begin
            prod  <= op_a * op_b;
            phase <= 1'b1;
          end else begin
            phase <= 1'b0;
            if (ri == 2'd2) lacc <= lacc + term;
            else sacc <= sacc + term;
            if (cj == 3'd2) begin
              cj <= '0;
              if (ri == 2'd2) state <= S_EMIT;
              else ri <= ri + 2'd1;
            end else begin
              cj <= cj + 3'd1;
            end
          end
        end
        S_EMIT: begin
          if (can_emit) begin
            out_valid             <= 1'b1;
            out_item.obs_index    <= 16'(obs_cnt);
            out_item.in_front     <= front;
            out_item.inlier       <= inl;
            out_item.inlier_count <= run_next;
            out_item.pass_done    <= item.last;
            if (item.last) begin
              running <= '0;
              obs_cnt <= '0;
            end else begin
              running <= run_next;
              obs_cnt <= (obs_cnt == OW'(MAX_OBSERVATIONS - 1)) ? '0 : obs_cnt + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/multi_camera_reprojection_inlier_counter_core.sv
// Top level of the inlier scoring core: configuration registers, front, queue and back.
// The back end scores one observation at a time on the one shared 29x29 multiplier
// (rotations, error terms and split squares in turn) and pops another request only
// after the current result is registered; mount writes are popped straight in idle.
// Reset (rst, synchronous): clears configuration, counters, queue and valids;
// the mount table holds nothing defined until written.
`default_nettype none
module multi_camera_reprojection_inlier_counter_core #(
  parameter int NUM_CAMERAS      = mcric_pkg::NUM_CAMERAS_DEF,
  parameter int MAX_OBSERVATIONS = mcric_pkg::MAX_OBSERVATIONS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire mcric_pkg::in_item_t  in_item,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output mcric_pkg::out_item_t      out_item,
  input  wire logic                 cfg_we,
  input  wire logic [2:0]           cfg_index,
  input  wire logic [47:0]          cfg_data
);
  import mcric_pkg::*;

  cfg_t     cfg;
  logic     q_push, q_ready, q_valid, q_pop;
  q_entry_t q_in, q_out;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROT_ROW_A: cfg.rot[0]    <= cfg_data;
        CFG_ROT_ROW_B: cfg.rot[1]    <= cfg_data;
        CFG_ROT_ROW_C: cfg.rot[2]    <= cfg_data;
        CFG_TRANS_XY:  cfg.trans_xy  <= cfg_data;
        CFG_TRANS_Z:   cfg.trans_z   <= cfg_data[23:0];
        CFG_FOCAL:     cfg.focal     <= cfg_data[15:0];
        CFG_PRINCIPAL: cfg.principal <= cfg_data[31:0];
        CFG_MAX_ERROR: cfg.max_err   <= cfg_data[11:0];
        default:       cfg           <= cfg;
      endcase
    end
  end

  mcric_front #(
    .NUM_CAMERAS(NUM_CAMERAS)
  ) u_front (
    .clk(clk), .rst(rst), .cfg(cfg),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .q_push(q_push), .q_ready(q_ready), .q_data(q_in)
  );

  mcric_queue u_queue (
    .clk(clk), .rst(rst),
    .push(q_push), .push_ready(q_ready), .push_data(q_in),
    .pop_valid(q_valid), .pop(q_pop), .pop_data(q_out)
  );

  mcric_back #(
    .NUM_CAMERAS(NUM_CAMERAS),
    .MAX_OBSERVATIONS(MAX_OBSERVATIONS)
  ) u_back (
    .clk(clk), .rst(rst), .cfg(cfg),
    .q_valid(q_valid), .q_pop(q_pop), .q_entry(q_out),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

endmodule
`default_nettype wire

>>> rtl/core/mcric_checker.sv
// Port-level checker for the inlier scoring core, bound to the top level.
`default_nettype none
`include "multi_camera_reprojection_inlier_counter_core_macros.svh"
module mcric_checker (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire mcric_pkg::out_item_t out_item
);

  // a held result keeps its payload
  `MCRIC_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_item), "result changed while stalled")

  // nothing shows right after reset
  `MCRIC_ASSERT_ALWAYS(a_reset_quiet, rst |=> !out_valid, "result valid after reset")

  // an inlier must lie in front of its camera
  `MCRIC_ASSERT(a_inlier_front, out_valid |-> (!out_item.inlier || out_item.in_front), "inlier behind camera")

  // the count includes the inlier just scored
  `MCRIC_ASSERT(a_count_nonzero, out_valid && out_item.inlier |-> out_item.inlier_count != 16'd0, "inlier with zero count")

endmodule

bind multi_camera_reprojection_inlier_counter_core mcric_checker u_mcric_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
);
`default_nettype wire

>>> dv/tb_multi_camera_reprojection_inlier_counter_core.sv
// Testbench of the inlier scoring core: directed table, then random observations and mount writes.
module tb_multi_camera_reprojection_inlier_counter_core;
  import mcric_pkg::*;

  typedef longint vec3_t [3];

  typedef struct {
    bit       reconf;
    in_item_t req;
    bit       typed;
    out_item_t res;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = CFG_ROT_ROW_A;
  logic [47:0] cfg_data = '0;

  // typed expectation travelling with the request
  logic        req_typed = 1'b0;
  out_item_t   req_res = '0;

  // predictor state
  logic [47:0] pose_rot [3];
  logic [47:0] pose_xy;
  logic [23:0] pose_z;
  logic [15:0] focal_m;
  logic [31:0] centre_m;
  logic [11:0] thr_m;
  logic [63:0] mount_m [16];
  logic [15:0] inliers_m;
  logic [15:0] index_m;

  out_item_t pending_scores[$];
  int        errors = 0;
  int        snd_idle = 0;
  int        rcv_idle = 0;
  bit        hold_armed = 0;
  bit        hold_used = 0;
  int        hold_left = 0;

  cfg_t settings [6];
  row_t rows [$];

  multi_camera_reprojection_inlier_counter_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20000000;
    $display("Some tests failed");
    $finish;
  end

  // round to 1/1024 m, saturate to 27 bits
  function automatic longint narrow(longint acc);
    longint t;
    t = (acc + 64'sd8192) >>> 14;
    if (t > 64'sd67108863) t = 64'sd67108863;
    if (t < -64'sd67108864) t = -64'sd67108864;
    return t;
  endfunction

  function automatic vec3_t turn(input logic [47:0] m [3], input vec3_t v);
    vec3_t o;
    longint acc;
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++)
        acc += longint'($signed(m[i][16*j +: 16])) * v[j];
      o[i] = narrow(acc);
    end
    return o;
  endfunction

  // point in the frame of its camera
  function automatic vec3_t cam_xyz(in_item_t it);
    vec3_t d, xb, e;
    logic [47:0] mr [3];
    logic [63:0] off;
    int base;
    base = int'(it.camera) * MOUNT_WORDS;
    d[0] = longint'($signed(it.point_x)) - longint'($signed(pose_xy[23:0]));
    d[1] = longint'($signed(it.point_y)) - longint'($signed(pose_xy[47:24]));
    d[2] = longint'($signed(it.point_z)) - longint'($signed(pose_z));
    xb = turn(pose_rot, d);
    for (int k = 0; k < 3; k++) mr[k] = mount_m[base + k][47:0];
    off = mount_m[base + 3];
    for (int k = 0; k < 3; k++) e[k] = xb[k] - longint'($signed(off[21*k +: 21]));
    return turn(mr, e);
  endfunction

  // score one observation and advance the pass counters
  function automatic out_item_t score_observation(in_item_t it);
    out_item_t r;
    vec3_t xc;
    logic signed [127:0] ex, ey, lim;
    bit front, inl;
    xc = cam_xyz(it);
    front = xc[2] >= 52;
    inl = 0;
    if (front) begin
      ex = longint'(focal_m) * xc[0]
         + (longint'(centre_m[15:0]) - longint'(it.meas_u)) * xc[2];
      ey = longint'(focal_m) * xc[1]
         + (longint'(centre_m[31:16]) - longint'(it.meas_v)) * xc[2];
      lim = longint'(thr_m) * xc[2];
      inl = (ex * ex + ey * ey) < (lim * lim);
    end
    if (inl && inliers_m != 16'hFFFF) inliers_m++;
    r.obs_index = index_m;
    r.in_front = front;
    r.inlier = inl;
    r.inlier_count = inliers_m;
    r.pass_done = it.last;
    if (it.last) begin
      inliers_m = '0;
      index_m = '0;
    end else begin
      index_m++;
    end
    return r;
  endfunction

  // predictor update and result check
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      pose_rot = '{default: '0};
      pose_xy = '0; pose_z = '0; focal_m = '0; centre_m = '0; thr_m = '0;
      inliers_m = '0; index_m = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ROT_ROW_A: pose_rot[0] = cfg_data;
          CFG_ROT_ROW_B: pose_rot[1] = cfg_data;
          CFG_ROT_ROW_C: pose_rot[2] = cfg_data;
          CFG_TRANS_XY:  pose_xy = cfg_data;
          CFG_TRANS_Z:   pose_z = cfg_data[23:0];
          CFG_FOCAL:     focal_m = cfg_data[15:0];
          CFG_PRINCIPAL: centre_m = cfg_data[31:0];
          default:       thr_m = cfg_data[11:0];
        endcase
      end
      if (in_valid && !in_stall) begin
        if (in_item.action == ACT_MOUNT) begin
          mount_m[int'(in_item.camera) * MOUNT_WORDS + int'(in_item.word_index)] =
            in_item.word_value;
        end else begin
          want = score_observation(in_item);
          pending_scores.insert(pending_scores.size(), req_typed ? req_res : want);
        end
      end
      if (out_valid && !out_stall) begin
        if (pending_scores.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, out_item);
          errors++;
        end else begin
          want = pending_scores.pop_front();
          if (out_item !== want) begin
            $display("%0t: result mismatch, expected %p, actual %p", $time, want, out_item);
            errors++;
          end
        end
      end
    end
  end

  // receiver: random stalls and one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_armed && !hold_used) begin
      hold_used = 1;
      hold_left = 400;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle);
    end
  end

  // offer one request; valid stays high afterwards
  task automatic send(in_item_t it, bit typed = 0, out_item_t res = '0);
    if ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    req_typed <= typed;
    req_res <= res;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    req_typed <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [47:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  // wait for the block to empty, then load a full register set
  task automatic load_settings(cfg_t c);
    settle();
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    write_reg(CFG_ROT_ROW_A, c.rot[0]);
    write_reg(CFG_ROT_ROW_B, c.rot[1]);
    write_reg(CFG_ROT_ROW_C, c.rot[2]);
    write_reg(CFG_TRANS_XY, c.trans_xy);
    write_reg(CFG_TRANS_Z, 48'(c.trans_z));
    write_reg(CFG_FOCAL, 48'(c.focal));
    write_reg(CFG_PRINCIPAL, 48'(c.principal));
    write_reg(CFG_MAX_ERROR, 48'(c.max_err));
    cfg_we <= 1'b0;
  endtask

  function automatic in_item_t obs(logic [1:0] cam, int x, int y, int z,
                                   int u, int v, bit last);
    in_item_t it;
    logic [191:0] noise;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = noise[$bits(in_item_t)-1:0];
    it.action = ACT_SCORE;
    it.camera = cam;
    it.point_x = 24'(x); it.point_y = 24'(y); it.point_z = 24'(z);
    it.meas_u = 16'(u); it.meas_v = 16'(v);
    it.last = last;
    return it;
  endfunction

  function automatic in_item_t mount_req(logic [1:0] cam, logic [1:0] idx,
                                         logic [63:0] val, bit last);
    in_item_t it;
    logic [191:0] noise;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = noise[$bits(in_item_t)-1:0];
    it.action = ACT_MOUNT;
    it.camera = cam;
    it.word_index = idx;
    it.word_value = val;
    it.last = last;
    return it;
  endfunction

  // new signed-permutation mount with a small offset
  task automatic rewrite_camera(logic [1:0] cam);
    int p [3];
    int j, tmp;
    logic [63:0] w;
    p = '{0, 1, 2};
    for (int i = 2; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = p[i]; p[i] = p[j]; p[j] = tmp;
    end
    for (int i = 0; i < 3; i++) begin
      w = {16'($urandom), 48'(($urandom_range(1) ? 16'hC000 : 16'h4000)) << (16 * p[i])};
      send(mount_req(cam, 2'(i), w, 1'($urandom_range(1))));
    end
    w = {1'($urandom_range(1)), 21'(int'($urandom_range(4000)) - 2000),
         21'(int'($urandom_range(4000)) - 2000), 21'(int'($urandom_range(4000)) - 2000)};
    send(mount_req(cam, 2'd3, w, 1'($urandom_range(1))));
  endtask

  function automatic int clamp(longint v, longint lo, longint hi);
    return int'(v < lo ? lo : (v > hi ? hi : v));
  endfunction

  // well-formed observation near the body, pixel near its projection
  task automatic send_observation(bit last);
    in_item_t it;
    vec3_t xc;
    longint bx, by, bz, nz;
    bx = longint'($signed(pose_xy[23:0]));
    by = longint'($signed(pose_xy[47:24]));
    bz = longint'($signed(pose_z));
    it = obs(2'($urandom_range(3)), 0, 0, 0, $urandom, $urandom, last);
    for (int t = 0; t < 6; t++) begin
      it.point_x = 24'(clamp(bx + int'($urandom_range(40000)) - 20000, -8388608, 8388607));
      it.point_y = 24'(clamp(by + int'($urandom_range(40000)) - 20000, -8388608, 8388607));
      it.point_z = 24'(clamp(bz + int'($urandom_range(40000)) - 20000, -8388608, 8388607));
      xc = cam_xyz(it);
      if (xc[2] >= 52) break;
    end
    if (xc[2] >= 52) begin
      nz = 2 * longint'(thr_m) + 2;
      it.meas_u = 16'(clamp(longint'(centre_m[15:0]) + longint'(focal_m) * xc[0] / xc[2]
                            + longint'($urandom_range(2 * nz)) - nz, 0, 65535));
      it.meas_v = 16'(clamp(longint'(centre_m[31:16]) + longint'(focal_m) * xc[1] / xc[2]
                            + longint'($urandom_range(2 * nz)) - nz, 0, 65535));
    end
    send(it);
  endtask

  initial begin
    out_item_t r;
    int ci, pick;
    logic [1:0] cam;

    // nominal, zero threshold, all high, all low, turned pose, long lens
    settings[0] = '{rot: '{48'h4000_0000_0000, 48'h0000_4000_0000, 48'h0000_0000_4000},
                    trans_xy: '0, trans_z: '0, focal: 16'd8000,
                    principal: 32'h0F00_1400, max_err: 12'd32};
    settings[1] = settings[0];
    settings[1].max_err = '0;
    settings[2] = '{rot: '{default: '1}, trans_xy: '1, trans_z: 24'h7FFFFF,
                    focal: '1, principal: '1, max_err: '1};
    settings[3] = '{rot: '{default: 48'h8000_8000_8000}, trans_xy: 48'h800000_800000,
                    trans_z: 24'h800000, focal: '0, principal: '0, max_err: '0};
    settings[4] = '{rot: '{48'h0000_0000_4000, 48'h4000_0000_0000, 48'h0000_C000_0000},
                    trans_xy: {24'd5000, 24'hFFEC78}, trans_z: 24'd3000,
                    focal: 16'd4000, principal: 32'h0A00_0C80, max_err: 12'd64};
    settings[5] = settings[0];
    settings[5].trans_xy = {24'h7FF000, 24'h810000};
    settings[5].focal = '1;
    settings[5].max_err = 12'hFFF;

    // directed table; the first two rows run on the reset settings
    r = '0;
    rows.insert(rows.size(), '{0, obs(0, 0, 0, 1000, 0, 0, 0), 1, r});
    r.obs_index = 16'd1; r.pass_done = 1'b1;
    rows.insert(rows.size(), '{0, obs(3, 8388607, -8388608, 8388607, 65535, 65535, 1), 1, r});
    rows.insert(rows.size(), '{1, obs(0, 0, 0, 2048, 5120, 3840, 0), 0, '0});
    rows.insert(rows.size(), '{0, obs(1, 0, 0, 52, 5120, 3840, 0), 0, '0});
    rows.insert(rows.size(), '{0, obs(2, 0, 0, 51, 5120, 3840, 0), 0, '0});
    rows.insert(rows.size(), '{0, obs(3, 0, 0, -2048, 5120, 3840, 0), 0, '0});
    rows.insert(rows.size(), '{0, obs(0, 1024, -1024, 4096, 7120, 1840, 0), 0, '0});
    rows.insert(rows.size(), '{0, obs(0, 1024, 0, 4096, 7184, 3840, 0), 0, '0});
    // error exactly at the threshold is not an inlier
    rows.insert(rows.size(), '{0, obs(0, 1024, 0, 4096, 7152, 3840, 0), 0, '0});
    rows.insert(rows.size(), '{0, obs(1, 8388607, 8388607, 8388607, 0, 65535, 0), 0, '0});
    rows.insert(rows.size(), '{0, obs(2, -8388608, -8388608, -8388608, 65535, 0, 0), 0, '0});
    // last on a mount write is ignored
    rows.insert(rows.size(), '{0, mount_req(2, 0, 64'hFFFF_0000_0000_4000, 1), 0, '0});
    rows.insert(rows.size(), '{0, mount_req(2, 3, 64'h8000_0000_0000_0000, 1), 0, '0});
    rows.insert(rows.size(), '{0, obs(2, 512, 512, 3000, 6485, 5205, 1), 0, '0});
    rows.insert(rows.size(), '{1, obs(0, 0, 0, 2048, 5120, 3840, 1), 0, '0});
    rows.insert(rows.size(), '{1, obs(1, 8388000, 8388000, 8388000, 40000, 30000, 0), 0, '0});
    rows.insert(rows.size(), '{0, obs(3, 0, 0, 0, 0, 0, 1), 0, '0});
    rows.insert(rows.size(), '{1, obs(2, -8388000, -8388000, -8388000, 0, 0, 1), 0, '0});

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // identity mounts for every camera
    for (int c = 0; c < 4; c++) begin
      send(mount_req(2'(c), 2'd0, 64'h0000_0000_0000_4000, 0));
      send(mount_req(2'(c), 2'd1, 64'h0000_0000_4000_0000, 0));
      send(mount_req(2'(c), 2'd2, 64'h0000_4000_0000_0000, 0));
      send(mount_req(2'(c), 2'd3, 64'h0, 0));
    end

    ci = 0;
    foreach (rows[i]) begin
      if (rows[i].reconf) begin
        load_settings(settings[ci]);
        ci++;
      end
      send(rows[i].req, rows[i].typed, rows[i].res);
    end

    // random phases over all settings and idle patterns
    for (int ph = 0; ph < 6; ph++) begin
      load_settings(settings[ph]);
      snd_idle = (ph % 3 == 0) ? 16 : (ph % 3 == 1) ? 58 : 0;
      rcv_idle = (ph % 3 == 0) ? 58 : (ph % 3 == 1) ? 16 : 0;
      for (int n = 0; n < 200; n++) begin
        if (ph == 0 && n == 50) hold_armed = 1;
        pick = $urandom_range(99);
        cam = 2'($urandom_range(3));
        if (pick < 4) begin
          send(mount_req(cam, 2'($urandom_range(3)), {$urandom, $urandom}, 0));
          rewrite_camera(cam);
        end else if (pick < 8) begin
          rewrite_camera(cam);
        end else if (pick < 13) begin
          send(obs(cam, $urandom, $urandom, $urandom, $urandom, $urandom,
                   1'($urandom_range(1))));
        end else begin
          send_observation($urandom_range(19) == 0);
        end
      end
    end

    settle();
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
